// ===== hw/rtl/lbp3_pkg.sv =====
// ----------------------------------------------------------------------------
// lbp3_pkg
// Shared constants, codes and types of the 3x3 local binary pattern core.
// ----------------------------------------------------------------------------
package lbp3_pkg;

	// parameter defaults
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;

	// register reset values
	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;

	// field widths
	localparam int PIX_W  = 8;
	localparam int CODE_W = 8;
	localparam int FW_W   = 12;
	localparam int FH_W   = 13;
	localparam int CFG_W  = 13;

	// input item kinds
	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	// configuration register indexes
	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// per-item command from the raster control to the window stage
	typedef struct packed {
		logic             we;       // pixel: write the line store back
		logic             use_r2;   // row two above is inside the frame
		logic             use_r1;   // row one above is inside the frame
		logic             at_col0;  // column zero: closes the previous row
		logic             made;     // item yields a code
		logic             eof;      // code is the frame's last
		logic [PIX_W-1:0] pix;      // new bottom pixel (zero when draining)
	} cmd_t;

endpackage

// ===== hw/rtl/lbp3_ram.sv =====
// ----------------------------------------------------------------------------
// lbp3_ram
// Generic simple dual-port RAM, one write and one registered read port,
// read-first on an address collision.
// ----------------------------------------------------------------------------
module lbp3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// storage and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/lbp3_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbp3_ctrl
// Frame size registers and raster / drain position counters. Turns each
// transaction into a line store read and a command for the window stage.
// ----------------------------------------------------------------------------
module lbp3_ctrl #(
	parameter int MAX_WIDTH  = lbp3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lbp3_pkg::MAX_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         write_enable,
	input  logic                         reg_index,
	input  logic [lbp3_pkg::CFG_W-1:0]   write_data,
	input  logic                         accept,
	input  logic                         op,
	input  logic [lbp3_pkg::PIX_W-1:0]   pixel,
	output logic                         cmd_valid,
	output lbp3_pkg::cmd_t               cmd,
	output logic [$clog2(MAX_WIDTH)-1:0] cmd_addr
);
	import lbp3_pkg::*;

	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 1);
	localparam int RST_W = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
	localparam int RST_H = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

	logic [CW-1:0] eff_w_q;
	logic [RW-1:0] eff_h_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] drain_q;
	logic          draining_q;

	logic [31:0]   w_raw, h_raw, w_clamp, h_clamp;
	logic          wrap;
	logic [CW-1:0] c, c_inc, col_d, drain_d;
	logic [RW-1:0] r, r_inc, row_d;
	logic          draining_d;

	// clamp written sizes to 1..MAX
	always_comb begin
		w_raw   = 32'(write_data[FW_W-1:0]);
		h_raw   = 32'(write_data[FH_W-1:0]);
		w_clamp = (w_raw == 32'd0) ? 32'd1 :
			(w_raw > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : w_raw;
		h_clamp = (h_raw == 32'd0) ? 32'd1 :
			(h_raw > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : h_raw;
	end

	// command decode and next position
	always_comb begin
		wrap       = (col_q >= eff_w_q) || (row_q >= eff_h_q);
		r          = wrap ? '0 : row_q;
		c          = wrap ? '0 : col_q;
		c_inc      = c + CW'(1);
		r_inc      = r + RW'(1);
		cmd        = '0;
		cmd_addr   = '0;
		cmd_valid  = 1'b0;
		col_d      = col_q;
		row_d      = row_q;
		drain_d    = drain_q;
		draining_d = draining_q;
		if (op == OP_PIXEL) begin
			cmd_valid  = accept;
			cmd.we     = 1'b1;
			cmd.use_r2 = (r >= RW'(2));
			cmd.use_r1 = (r >= RW'(1));
			cmd.at_col0 = (c == '0);
			cmd.made   = (c == '0) ? (r >= RW'(2)) : (r >= RW'(1));
			cmd.pix    = pixel;
			cmd_addr   = c[AW-1:0];
			draining_d = 1'b0;
			col_d      = c_inc;
			row_d      = r;
			if (c_inc >= eff_w_q) begin
				col_d = '0;
				row_d = r_inc;
				if (r_inc >= eff_h_q) begin
					row_d      = '0;
					draining_d = 1'b1;
					drain_d    = '0;
				end
			end
		end else if (draining_q) begin
			cmd_valid = accept;
			if (drain_q < eff_w_q) begin
				// last row's codes: row below the frame reads zero
				cmd.use_r2  = (eff_h_q >= RW'(2));
				cmd.use_r1  = 1'b1;
				cmd.at_col0 = (drain_q == '0);
				cmd.made    = (drain_q == '0) ? (eff_h_q >= RW'(2)) : 1'b1;
				cmd_addr    = drain_q[AW-1:0];
				drain_d     = drain_q + CW'(1);
			end else begin
				// closes the last row at its right edge
				cmd.at_col0 = 1'b1;
				cmd.made    = 1'b1;
				cmd.eof     = 1'b1;
				draining_d  = 1'b0;
				drain_d     = '0;
			end
		end
	end

	// registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q    <= CW'(RST_W);
			eff_h_q    <= RW'(RST_H);
			col_q      <= '0;
			row_q      <= '0;
			drain_q    <= '0;
			draining_q <= 1'b0;
		end else if (write_enable) begin
			if (reg_index == REG_FRAME_WIDTH) begin
				eff_w_q <= w_clamp[CW-1:0];
			end else begin
				eff_h_q <= h_clamp[RW-1:0];
			end
			col_q      <= '0;
			row_q      <= '0;
			drain_q    <= '0;
			draining_q <= 1'b0;
		end else if (accept) begin
			col_q      <= col_d;
			row_q      <= row_d;
			drain_q    <= drain_d;
			draining_q <= draining_d;
		end
	end

`ifndef SYNTH
	// a flush only runs from the start of the raster
	a_drain_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> (col_q == '0) && (row_q == '0))
		else $error("drain pending with raster position not at origin");

	// a command only comes from an accepted transaction
	a_cmd_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> accept)
		else $error("command issued without an accepted transaction");

	// pixels never close a frame
	a_pixel_no_eof: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.we |-> !cmd.eof)
		else $error("end of frame flagged on a pixel command");
`endif

endmodule

// ===== hw/rtl/lbp3_window.sv =====
// ----------------------------------------------------------------------------
// lbp3_window
// Line store read-back stage: merges RAM data with forwarding, writes the
// shifted rows back, shifts the 3x3 window and holds the output register.
// ----------------------------------------------------------------------------
module lbp3_window #(
	parameter int MAX_WIDTH = lbp3_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  lbp3_pkg::cmd_t               cmd,
	input  logic [$clog2(MAX_WIDTH)-1:0] cmd_addr,
	input  logic [2*lbp3_pkg::PIX_W-1:0] rd_data,
	output logic                         wr_en,
	output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	output logic [2*lbp3_pkg::PIX_W-1:0] wr_data,
	output logic                         item_stall,
	output logic                         code_valid,
	input  logic                         code_stall,
	output logic [lbp3_pkg::CODE_W-1:0]  code,
	output logic                         end_of_frame
);
	import lbp3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic             valid_s1;
	cmd_t             cmd_s1;
	logic [AW-1:0]    addr_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_r1_s1, fwd_r2_s1;
	logic [PIX_W-1:0] win_q [6];

	logic             adv;
	logic             fwd_d;
	logic [PIX_W-1:0] r1_raw, r2_raw;
	logic [PIX_W-1:0] col [3];
	logic [PIX_W-1:0] n [9];
	logic [PIX_W-1:0] ctr;
	logic [CODE_W-1:0] code_d;

	// stage advance and upstream stall
	assign adv        = valid_s1 && (!cmd_s1.made || !code_valid || !code_stall);
	assign item_stall = valid_s1 && !adv;

	// same column written back at the edge of this read
	assign fwd_d = valid_s1 && adv && cmd_s1.we && (addr_s1 == cmd_addr);

	// line data, new column and pattern
	always_comb begin
		r1_raw = fwd_s1 ? fwd_r1_s1 : rd_data[PIX_W-1:0];
		r2_raw = fwd_s1 ? fwd_r2_s1 : rd_data[2*PIX_W-1:PIX_W];
		col[0] = cmd_s1.use_r2 ? r2_raw : '0;
		col[1] = cmd_s1.use_r1 ? r1_raw : '0;
		col[2] = cmd_s1.pix;
		for (int i = 0; i < 6; i++) begin
			n[i] = win_q[i];
		end
		for (int i = 0; i < 3; i++) begin
			n[6 + i] = cmd_s1.at_col0 ? '0 : col[i];
		end
		ctr       = n[4];
		code_d[7] = (n[0] >= ctr);
		code_d[6] = (n[3] >= ctr);
		code_d[5] = (n[6] >= ctr);
		code_d[4] = (n[7] >= ctr);
		code_d[3] = (n[8] >= ctr);
		code_d[2] = (n[5] >= ctr);
		code_d[1] = (n[2] >= ctr);
		code_d[0] = (n[1] >= ctr);
	end

	// write-back: row one above moves down, pixel becomes row one above
	assign wr_en   = adv && cmd_s1.we;
	assign wr_addr = addr_s1;
	assign wr_data = {r1_raw, cmd_s1.pix};

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (cmd_valid) begin
			valid_s1 <= 1'b1;
			fwd_s1   <= fwd_d;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (cmd_valid) begin
			cmd_s1    <= cmd;
			addr_s1   <= cmd_addr;
			fwd_r1_s1 <= cmd_s1.pix;
			fwd_r2_s1 <= r1_raw;
		end
	end

	// window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i]     <= cmd_s1.at_col0 ? '0 : win_q[3 + i];
				win_q[3 + i] <= col[i];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid <= 1'b0;
		end else if (adv && cmd_s1.made) begin
			code_valid <= 1'b1;
		end else if (!code_stall) begin
			code_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cmd_s1.made) begin
			code         <= code_d;
			end_of_frame <= cmd_s1.eof;
		end
	end

`ifndef SYNTH
	// no new read while the stage holds its RAM data
	a_hold_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |-> !cmd_valid)
		else $error("line store read while stage one is held");

	// a waiting code is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_stall |-> !(adv && cmd_s1.made))
		else $error("pending code overwritten");

	// end of frame only on the closing column
	a_eof_col0: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && cmd_s1.eof |-> cmd_s1.at_col0 && cmd_s1.made && !cmd_s1.we)
		else $error("end of frame on a column other than the closing one");
`endif

endmodule

// ===== hw/rtl/local_binary_pattern_3x3_core.sv =====
// ----------------------------------------------------------------------------
// local_binary_pattern_3x3_core
// 8-neighbour 3x3 local binary pattern over a raster stream of gray pixels.
// ----------------------------------------------------------------------------
// Input channel (item_valid / item_stall): op = 0 carries a pixel in raster
// order, op = 1 is a drain tick. After a frame's last pixel, send
// frame_width + 1 drain ticks to flush the last row of codes.
// Output channel (code_valid / code_stall): one code per pixel in raster
// order, end_of_frame set on the frame's last code. Codes trail the input
// by one row plus one pixel of transactions.
// A window's last transaction waits in the RAM read stage behind a stalled
// code, then enters the output register. Throughput: one transaction per
// cycle while item_stall is low, set by the single line store RAM (one read
// and one write per cycle, 16 bits wide holding both previous rows,
// MAX_WIDTH deep); a write-back to the column being read is forwarded.
// Reset: raster at row 0 column 0, no flush pending, frame 640 x 480, line
// store contents left as they are (rows above the frame are masked).
// Stall: a stalled code waits in the output register; transactions yielding
// no code pass on, and one that does raises item_stall. Configuration writes
// restart the frame and must be made only while idle (not enforced here).
// ----------------------------------------------------------------------------
module local_binary_pattern_3x3_core #(
	parameter int MAX_WIDTH  = lbp3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lbp3_pkg::MAX_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        write_enable,
	input  logic                        reg_index,
	input  logic [lbp3_pkg::CFG_W-1:0]  write_data,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        op,
	input  logic [lbp3_pkg::PIX_W-1:0]  pixel,
	output logic                        code_valid,
	input  logic                        code_stall,
	output logic [lbp3_pkg::CODE_W-1:0] code,
	output logic                        end_of_frame
);
	import lbp3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic                 accept;
	logic                 cmd_valid;
	cmd_t                 cmd;
	logic [AW-1:0]        cmd_addr;
	logic [2*PIX_W-1:0]   rd_data;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [2*PIX_W-1:0]   wr_data;

	assign accept = item_valid && !item_stall;

	// raster control
	lbp3_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.accept       (accept),
		.op           (op),
		.pixel        (pixel),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_addr     (cmd_addr)
	);

	// line store: [15:8] two rows above, [7:0] one row above
	lbp3_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.rd_en   (cmd_valid),
		.rd_addr (cmd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// window, pattern and output register
	lbp3_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_addr     (cmd_addr),
		.rd_data      (rd_data),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.item_stall   (item_stall),
		.code_valid   (code_valid),
		.code_stall   (code_stall),
		.code         (code),
		.end_of_frame (end_of_frame)
	);

endmodule

// ===== tb/tb_local_binary_pattern_3x3_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_local_binary_pattern_3x3_core
// Self-checking testbench for the 3x3 local binary pattern core.
// A queue of pixel and drain transactions feeds a clocked driver. Each
// accepted transaction runs through a behavioral copy of the raster, line
// stores and window, and the codes it yields wait in an expectation queue.
// A clocked monitor compares every accepted code against that queue. Frame
// sizes cover zero sizes and many small frames. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_local_binary_pattern_3x3_core;
	import lbp3_pkg::*;

	localparam int MAX_W      = MAX_WIDTH_DEF;
	localparam int MAX_H      = MAX_HEIGHT_DEF;
	localparam int CYCLE_CAP  = 200000;
	localparam int SETTLE     = 8;
	localparam int RAND_ITEMS = 1750;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		op_t              kind;
		logic [PIX_W-1:0] gray;
	} stream_item_t;

	typedef struct {
		logic [CODE_W-1:0] pattern;
		logic              last;
	} code_item_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               write_enable = 1'b0;
	logic               reg_index    = REG_FRAME_WIDTH;
	logic [CFG_W-1:0]   write_data   = '0;
	logic               item_valid   = 1'b0;
	logic               item_stall;
	logic               op           = OP_PIXEL;
	logic [PIX_W-1:0]   pixel        = '0;
	logic               code_valid;
	logic               code_stall   = 1'b0;
	logic [CODE_W-1:0]  code;
	logic               end_of_frame;

	stream_item_t stream_q[$];
	code_item_t   code_q[$];
	int unsigned  items_left;
	int unsigned  err_cnt;
	int unsigned  cycle_cnt;
	int unsigned  send_idle_pct;
	int unsigned  recv_stall_pct;
	int unsigned  phase_cnt;

	// behavioral image of the core
	logic [PIX_W-1:0] line_up1 [0:MAX_W-1];
	logic [PIX_W-1:0] line_up2 [0:MAX_W-1];
	logic [PIX_W-1:0] win [0:5];
	int unsigned      col_pos;
	int unsigned      row_pos;
	int unsigned      drain_pos;
	bit               flushing;
	logic [FW_W-1:0]  width_reg;
	logic [FH_W-1:0]  height_reg;

	local_binary_pattern_3x3_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.op           (op),
		.pixel        (pixel),
		.code_valid   (code_valid),
		.code_stall   (code_stall),
		.code         (code),
		.end_of_frame (end_of_frame)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned width_eff(input int unsigned w);
		if (w == 0) return 1;
		if (w > MAX_W) return MAX_W;
		return w;
	endfunction

	function automatic int unsigned height_eff(input int unsigned h);
		if (h == 0) return 1;
		if (h > MAX_H) return MAX_H;
		return h;
	endfunction

	// n is the window column by column: n[col * 3 + row]
	function automatic logic [CODE_W-1:0] lbp_of(input logic [8:0][PIX_W-1:0] n);
		logic [PIX_W-1:0] c;
		c = n[4];
		return {n[0] >= c, n[3] >= c, n[6] >= c, n[7] >= c,
			n[8] >= c, n[5] >= c, n[2] >= c, n[1] >= c};
	endfunction

	task automatic lbp_reset();
		for (int k = 0; k < MAX_W; k++) begin
			line_up1[k] = '0;
			line_up2[k] = '0;
		end
		for (int k = 0; k < 6; k++) win[k] = '0;
		col_pos    = 0;
		row_pos    = 0;
		drain_pos  = 0;
		flushing   = 1'b0;
		width_reg  = FW_W'(FRAME_WIDTH_RST);
		height_reg = FH_W'(FRAME_HEIGHT_RST);
	endtask

	task automatic lbp_config(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		if (idx == REG_FRAME_WIDTH) width_reg = val[FW_W-1:0];
		else height_reg = val[FH_W-1:0];
		col_pos   = 0;
		row_pos   = 0;
		drain_pos = 0;
		flushing  = 1'b0;
	endtask

	// slide the window by one column at raster position (r, c)
	task automatic slide_window(input int unsigned r, input int unsigned c,
			input int unsigned h, input logic [2:0][PIX_W-1:0] newcol);
		logic [8:0][PIX_W-1:0] n;
		code_item_t            e;
		for (int k = 0; k < 6; k++) n[k] = win[k];
		if (c == 0) begin
			// closes the previous row; right edge is outside the frame
			n[6] = '0; n[7] = '0; n[8] = '0;
			if (r >= 2) begin
				e.pattern = lbp_of(n);
				e.last    = (r == h + 1);
				code_q = {code_q, e};
			end
			win[0] = '0; win[1] = '0; win[2] = '0;
		end else begin
			n[6] = newcol[0]; n[7] = newcol[1]; n[8] = newcol[2];
			if (r >= 1) begin
				e.pattern = lbp_of(n);
				e.last    = 1'b0;
				code_q = {code_q, e};
			end
			win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
		end
		win[3] = newcol[0]; win[4] = newcol[1]; win[5] = newcol[2];
	endtask

	task automatic lbp_predict_item(input op_t kind, input logic [PIX_W-1:0] gray);
		int unsigned            w;
		int unsigned            h;
		int unsigned            r;
		int unsigned            c;
		logic [2:0][PIX_W-1:0]  col;
		w = width_eff(32'(width_reg));
		h = height_eff(32'(height_reg));
		if (kind == OP_PIXEL) begin
			flushing = 1'b0;
			if (col_pos >= w || row_pos >= h) begin
				col_pos = 0;
				row_pos = 0;
			end
			r = row_pos;
			c = col_pos;
			col[0] = (r >= 2) ? line_up2[c] : '0;
			col[1] = (r >= 1) ? line_up1[c] : '0;
			col[2] = gray;
			line_up2[c] = line_up1[c];
			line_up1[c] = gray;
			slide_window(r, c, h, col);
			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r >= h) begin
					r = 0;
					flushing  = 1'b1;
					drain_pos = 0;
				end
			end
			col_pos = c;
			row_pos = r;
		end else if (flushing) begin
			if (drain_pos < w) begin
				col[0] = (h >= 2) ? line_up2[drain_pos] : '0;
				col[1] = line_up1[drain_pos];
				col[2] = '0;
				slide_window(h, drain_pos, h, col);
				drain_pos++;
			end else begin
				col = '0;
				slide_window(h + 1, 0, h, col);
				flushing  = 1'b0;
				drain_pos = 0;
			end
		end
	endtask

	// driver: holds a stalled transaction, else loads the next one or idles
	always @(posedge clk) begin : drive_proc
		stream_item_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				lbp_predict_item(op_t'(op), pixel);
				items_left--;
			end
			if (item_valid && item_stall) begin
				// payload stays put
			end else if (stream_q.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				nxt = stream_q.pop_front();
				item_valid <= 1'b1;
				op         <= nxt.kind;
				pixel      <= nxt.gray;
			end else begin
				item_valid <= 1'b0;
				op         <= 1'($urandom_range(1));
				pixel      <= PIX_W'($urandom_range(255));
			end
		end
	end

	// monitor: random stall, compare each accepted code
	always @(posedge clk) begin : check_proc
		code_item_t want;
		if (!arst_n) begin
			code_stall <= 1'b0;
		end else begin
			if (code_valid === 1'b1 && !code_stall) begin
				if (code_q.size() == 0) begin
					$error("code: no transaction expected, got %0h", code);
					err_cnt++;
				end else begin
					want = code_q.pop_front();
					if (code !== want.pattern) begin
						$error("code: expected %0h, got %0h", want.pattern, code);
						err_cnt++;
					end
					if (end_of_frame !== want.last) begin
						$error("end_of_frame: expected %0b, got %0b",
							want.last, end_of_frame);
						err_cnt++;
					end
				end
			end
			code_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_CAP) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic push_item(input op_t kind, input logic [PIX_W-1:0] gray);
		stream_item_t it;
		it.kind = kind;
		it.gray = gray;
		stream_q = {stream_q, it};
		items_left++;
	endtask

	// wait for every transaction and code, then let the pipeline settle
	task automatic wait_idle();
		while (items_left != 0 || code_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		write_enable <= 1'b1;
		reg_index    <= idx;
		write_data   <= val;
		lbp_config(idx, val);
		@(posedge clk);
		write_enable <= 1'b0;
	endtask

	// new phase: idle pattern rotates, both sizes written in random order
	task automatic start_phase(input int unsigned w, input int unsigned h);
		case (idle_mode_t'(phase_cnt % 4))
			IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 88; recv_stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 88; end
			default:       begin send_idle_pct = 26; recv_stall_pct = 26; end
		endcase
		phase_cnt++;
		if ($urandom_range(1)) begin
			reg_write(REG_FRAME_WIDTH, CFG_W'(w));
			reg_write(REG_FRAME_HEIGHT, CFG_W'(h));
		end else begin
			reg_write(REG_FRAME_HEIGHT, CFG_W'(h));
			reg_write(REG_FRAME_WIDTH, CFG_W'(w));
		end
	endtask

	// half the time near a base level so ties and near-ties are common
	function automatic logic [PIX_W-1:0] gray_value(input logic [PIX_W-1:0] base);
		case ($urandom_range(3))
			0:       return PIX_W'($urandom_range(255));
			3:       return $urandom_range(1) ? 8'hff : 8'h00;
			default: return base + PIX_W'($urandom_range(2));
		endcase
	endfunction

	// one frame plus its flush; returns transactions that do real work
	task automatic push_frame(input int unsigned w, input int unsigned h,
			input bit noisy, output int unsigned counted);
		logic [PIX_W-1:0] base;
		int unsigned      ndrain;
		int unsigned      sel;
		base    = PIX_W'($urandom_range(255));
		counted = 0;
		for (int p = 0; p < w * h; p++) begin
			if (noisy && $urandom_range(19) == 0)
				push_item(OP_DRAIN, PIX_W'($urandom_range(255)));
			push_item(OP_PIXEL, gray_value(base));
			counted++;
		end
		sel = $urandom_range(9);
		if (sel < 7) ndrain = w + 1;
		else if (sel == 7) ndrain = $urandom_range(w);
		else ndrain = w + 1 + $urandom_range(1, 3);
		for (int d = 0; d < ndrain; d++) begin
			push_item(OP_DRAIN, PIX_W'($urandom_range(255)));
			if (d <= w) counted++;
		end
	endtask

	initial begin : stim_proc
		int unsigned w;
		int unsigned h;
		int unsigned done;
		int unsigned got;
		int unsigned nframes;
		items_left     = 0;
		err_cnt        = 0;
		cycle_cnt      = 0;
		phase_cnt      = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		lbp_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: 3x3 frame with extremes and ties, full flush, stray drain,
		// then a partial flush abandoned by an early pixel
		start_phase(3, 3);
		push_item(OP_PIXEL, 8'h00); push_item(OP_PIXEL, 8'hff); push_item(OP_PIXEL, 8'h80);
		push_item(OP_PIXEL, 8'h80); push_item(OP_PIXEL, 8'h80); push_item(OP_PIXEL, 8'h80);
		push_item(OP_PIXEL, 8'hff); push_item(OP_PIXEL, 8'h00); push_item(OP_PIXEL, 8'hff);
		for (int d = 0; d < 4; d++) push_item(OP_DRAIN, 8'hff);
		push_item(OP_DRAIN, 8'h00);
		for (int p = 0; p < 3; p++) push_item(OP_PIXEL, 8'h7f);
		for (int p = 0; p < 3; p++) push_item(OP_PIXEL, 8'h01);
		for (int p = 0; p < 3; p++) push_item(OP_PIXEL, 8'h7f);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_PIXEL, 8'h55);
		wait_idle();

		// zero sizes act as one
		start_phase(0, 0);
		push_frame(1, 1, 1'b0, got);
		push_frame(1, 1, 1'b0, got);
		wait_idle();
		start_phase(0, 3);
		push_frame(1, 3, 1'b0, got);
		wait_idle();

		// random frames, mostly small
		done = 0;
		while (done < RAND_ITEMS) begin
			case ($urandom_range(19))
				0:       w = 0;
				1, 2:    w = $urandom_range(9, 40);
				default: w = $urandom_range(1, 8);
			endcase
			case ($urandom_range(19))
				0:       h = 0;
				1:       h = $urandom_range(7, 20);
				default: h = $urandom_range(1, 6);
			endcase
			start_phase(w, h);
			nframes = $urandom_range(1, 3);
			for (int f = 0; f < nframes; f++) begin
				push_frame(width_eff(w), height_eff(h), $urandom_range(4) == 0, got);
				done += got;
			end
			wait_idle();
		end

		if (err_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
